// ===== design/sorted_priority_queue_unit_macros.svh =====
// assertion macros for the sorted priority queue unit
// used by the rtl files that carry concurrent checks; needs a clk and rst in scope
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SPQ_ASSERT_ALWAYS(lbl, cond, msg)
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/spq_pkg.sv =====
// shared types and constants of the sorted priority queue unit
// no dependencies; used by spq_cell, spq_ctrl and the top level
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_W     = 5;
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 8;

  typedef logic [CNT_W-1:0] count_t;

  // action codes of an input beat
  localparam logic [1:0] ACT_PUSH     = 2'd0;
  localparam logic [1:0] ACT_POP      = 2'd1;
  localparam logic [1:0] ACT_REMOVE   = 2'd2;
  localparam logic [1:0] ACT_POP_UPTO = 2'd3;

  // status codes of a result beat
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // operation broadcast to every cell
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic [1:0]               action;
    logic [PRIO_W-1:0]        key;
    logic signed [DATA_W-1:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        prio;
    logic                     valid;
  } cell_link_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// one slot of the sorted chain: holds an entry and trades it with its neighbors
// depends on spq_pkg
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire spq_pkg::cell_link_t from_left,
  input  wire logic               ins_in,
  input  wire logic               del_in,
  input  wire spq_pkg::cell_link_t from_right,
  output spq_pkg::cell_link_t     link,
  output logic                    ins_out,
  output logic                    del_out
);

  logic signed [spq_pkg::DATA_W-1:0] data;
  logic [spq_pkg::PRIO_W-1:0]        prio;
  logic                              valid;

  logic signed [spq_pkg::DATA_W-1:0] data_next;
  logic [spq_pkg::PRIO_W-1:0]        prio_next;
  logic                              valid_next;
  logic                              match;

  assign link = '{data: data, prio: prio, valid: valid};

  // insert point: first slot that is empty or holds a larger priority
  assign ins_out = !valid || (prio > ctrl.key);

  // delete match for the current action
  always_comb begin
    unique case (ctrl.action)
      spq_pkg::ACT_POP:      match = valid;
      spq_pkg::ACT_REMOVE:   match = valid && (prio == ctrl.key);
      spq_pkg::ACT_POP_UPTO: match = valid && (prio <= ctrl.key);
      default:               match = 1'b0;
    endcase
  end

  // slots at or after the first match close the gap
  assign del_out = del_in || match;

  // next contents
  always_comb begin
    data_next  = data;
    prio_next  = prio;
    valid_next = valid;
    unique case (ctrl.op)
      spq_pkg::CELL_INSERT: begin
        if (ins_in) begin
          data_next  = from_left.data;
          prio_next  = from_left.prio;
          valid_next = from_left.valid;
        end else if (ins_out) begin
          data_next  = ctrl.data;
          prio_next  = ctrl.key;
          valid_next = 1'b1;
        end
      end
      spq_pkg::CELL_DELETE: begin
        if (del_out) begin
          data_next  = from_right.data;
          prio_next  = from_right.prio;
          valid_next = from_right.valid;
        end
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/spq_ctrl.sv =====
// sequencer of the sorted priority queue: takes a command, steps the cell chain,
// registers the result beat; depends on spq_pkg and the assertion macro header
`default_nettype none

`include "sorted_priority_queue_unit_macros.svh"

module spq_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [1:0]                        action,
  input  wire logic signed [spq_pkg::DATA_W-1:0] entry_data,
  input  wire logic [spq_pkg::PRIO_W-1:0]        item_priority,
  input  wire logic                              any_match,
  input  wire logic signed [spq_pkg::DATA_W-1:0] head_data,
  output logic                                   busy,
  output spq_pkg::cell_ctrl_t                    ctrl,
  output logic                                   done,
  output logic signed [spq_pkg::DATA_W-1:0]      result_data,
  output logic [1:0]                             status,
  output logic [spq_pkg::COUNT_W-1:0]            removed_count,
  output logic [spq_pkg::COUNT_W-1:0]            occupancy
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_RUN  = 1'b1;

  logic [0:0]                        state;
  logic [0:0]                        state_next;
  logic [1:0]                        act;
  logic [spq_pkg::PRIO_W-1:0]        key;
  logic signed [spq_pkg::DATA_W-1:0] data;
  spq_pkg::count_t                   occ;
  spq_pkg::count_t                   occ_next;
  spq_pkg::count_t                   removed;
  spq_pkg::count_t                   removed_next;

  logic                              finish;
  logic [1:0]                        status_next;
  logic signed [spq_pkg::DATA_W-1:0] result_next;
  logic                              full;

  assign busy = (state == S_RUN);
  assign full = (occ == spq_pkg::count_t'(spq_pkg::QUEUE_DEPTH));

  // one chain step per cycle while running
  always_comb begin
    state_next   = state;
    occ_next     = occ;
    removed_next = removed;
    finish       = 1'b0;
    status_next  = spq_pkg::ST_OK;
    result_next  = '0;
    ctrl         = '{op: spq_pkg::CELL_HOLD, action: act, key: key, data: data};
    if (state == S_IDLE) begin
      if (start) begin
        state_next   = S_RUN;
        removed_next = '0;
      end
    end else begin
      unique case (act)
        spq_pkg::ACT_PUSH: begin
          finish = 1'b1;
          if (full) begin
            status_next = spq_pkg::ST_FULL;
          end else begin
            ctrl.op  = spq_pkg::CELL_INSERT;
            occ_next = spq_pkg::count_t'(occ + 1'b1);
          end
        end
        spq_pkg::ACT_POP: begin
          finish = 1'b1;
          if (any_match) begin
            ctrl.op      = spq_pkg::CELL_DELETE;
            result_next  = head_data;
            removed_next = spq_pkg::count_t'(1);
            occ_next     = spq_pkg::count_t'(occ - 1'b1);
          end else begin
            status_next = spq_pkg::ST_EMPTY;
          end
        end
        spq_pkg::ACT_REMOVE, spq_pkg::ACT_POP_UPTO: begin
          if (any_match) begin
            // drop the first matching entry, keep going
            ctrl.op      = spq_pkg::CELL_DELETE;
            removed_next = spq_pkg::count_t'(removed + 1'b1);
            occ_next     = spq_pkg::count_t'(occ - 1'b1);
          end else begin
            finish = 1'b1;
            if (occ == '0 && removed == '0) begin
              status_next = spq_pkg::ST_EMPTY;
            end else if (act == spq_pkg::ACT_REMOVE && removed == '0) begin
              status_next = spq_pkg::ST_NOT_FOUND;
            end
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
      if (finish) begin
        state_next = S_IDLE;
      end
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      act  <= action;
      key  <= item_priority;
      data <= entry_data;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      occ     <= '0;
      removed <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      occ     <= occ_next;
      removed <= removed_next;
      done    <= finish;
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (finish) begin
      result_data   <= result_next;
      status        <= status_next;
      removed_count <= spq_pkg::COUNT_W'(removed_next);
      occupancy     <= spq_pkg::COUNT_W'(occ_next);
    end
  end

  `SPQ_ASSERT_IMPL(a_done_idle, done, !busy, "result beat while still running")
  `SPQ_ASSERT_ALWAYS(a_occ_bound, occ <= spq_pkg::count_t'(spq_pkg::QUEUE_DEPTH), "occupancy overflow")
  `SPQ_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not start")
  `SPQ_ASSERT_NEXT(a_push_grows, busy && act == spq_pkg::ACT_PUSH && !full, done && occ == spq_pkg::count_t'($past(occ) + 1'b1), "push did not add one entry")
  `SPQ_ASSERT_IMPL(a_pop_one, finish && act == spq_pkg::ACT_POP, removed_next <= spq_pkg::count_t'(1), "pop removed more than one entry")

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue_unit.sv =====
// sorted priority queue: a chain of 16 cells kept in ascending priority, ties in arrival order.
// push and pop run a single chain step before the done beat; remove and pop-up-to run one
// chain shift per removed entry, plus a last step that finds no match.
// a new command is taken in the cycle the done beat is shown; done cannot be stalled.
// rst (synchronous, active high) empties the queue and returns to idle.
`default_nettype none

module sorted_priority_queue_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [1:0]                        action,
  input  wire logic signed [spq_pkg::DATA_W-1:0] entry_data,
  input  wire logic [spq_pkg::PRIO_W-1:0]        item_priority,
  output logic                                   busy,
  output logic                                   done,
  output logic signed [spq_pkg::DATA_W-1:0]      result_data,
  output logic [1:0]                             status,
  output logic [spq_pkg::COUNT_W-1:0]            removed_count,
  output logic [spq_pkg::COUNT_W-1:0]            occupancy
);

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::cell_link_t link [spq_pkg::QUEUE_DEPTH];
  logic                ins  [spq_pkg::QUEUE_DEPTH];
  logic                del  [spq_pkg::QUEUE_DEPTH];

  localparam spq_pkg::cell_link_t EMPTY_LINK = '{data: '0, prio: '0, valid: 1'b0};

  // the cell chain, slot 0 is the head
  for (genvar g = 0; g < spq_pkg::QUEUE_DEPTH; g++) begin : g_cell
    spq_pkg::cell_link_t from_left;
    spq_pkg::cell_link_t from_right;
    logic                ins_in;
    logic                del_in;

    if (g == 0) begin : g_head
      assign from_left = EMPTY_LINK;
      assign ins_in    = 1'b0;
      assign del_in    = 1'b0;
    end else begin : g_body
      assign from_left = link[g-1];
      assign ins_in    = ins[g-1];
      assign del_in    = del[g-1];
    end

    if (g == spq_pkg::QUEUE_DEPTH - 1) begin : g_tail
      assign from_right = EMPTY_LINK;
    end else begin : g_inner
      assign from_right = link[g+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .from_left  (from_left),
      .ins_in     (ins_in),
      .del_in     (del_in),
      .from_right (from_right),
      .link       (link[g]),
      .ins_out    (ins[g]),
      .del_out    (del[g])
    );
  end

  // sequencer
  spq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .entry_data    (entry_data),
    .item_priority (item_priority),
    .any_match     (del[spq_pkg::QUEUE_DEPTH-1]),
    .head_data     (link[0].data),
    .busy          (busy),
    .ctrl          (ctrl),
    .done          (done),
    .result_data   (result_data),
    .status        (status),
    .removed_count (removed_count),
    .occupancy     (occupancy)
  );

endmodule

`default_nettype wire
